[hdl/ssd_pkg.sv]
// Shared types, constants and segment code helpers for the seven-segment scan driver.
// No dependencies; used by every module in hdl/.
package ssd_pkg;

    localparam int MAX_DIGITS_DEF = 8;
    localparam int MAG_W          = 32;
    localparam int BCD_DIGITS     = 10;   // enough for 4294967295
    localparam int CNT_W          = $clog2(MAG_W);

    localparam logic [7:0] BLANK_CODE = 8'hFF;
    localparam logic [7:0] MINUS_CODE = 8'hBF;
    localparam logic [7:0] POINT_MASK = 8'h7F;
    localparam logic [7:0] POINT_BIT  = 8'h80;
    localparam logic [7:0] SEL_OFF_CA = 8'h00;
    localparam logic [7:0] SEL_OFF_CC = 8'hFF;

    typedef enum logic [2:0] {
        K_NUMBER = 3'd0,
        K_HEX    = 3'd1,
        K_SYMBOL = 3'd2,
        K_BLANK  = 3'd3,
        K_TICK   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CFG_CATHODE = 2'd0,
        CFG_COUNT   = 2'd1,
        CFG_ON      = 2'd2,
        CFG_OFF     = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        SYM_MINUS = 1'b0,
        SYM_POINT = 1'b1
    } t_sym;

    typedef logic [BCD_DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        logic clear;
        logic shift;
        logic bit_in;
    } t_chain_ctl;

    typedef struct packed {
        logic [2:0] index;
        logic       blank;
    } t_scan;

    function automatic logic [7:0] hex_code(input logic [3:0] v);
        logic [7:0] c;
        case (v)
            4'h0: c = 8'hC0;
            4'h1: c = 8'hF9;
            4'h2: c = 8'hA4;
            4'h3: c = 8'hB0;
            4'h4: c = 8'h99;
            4'h5: c = 8'h92;
            4'h6: c = 8'h82;
            4'h7: c = 8'hF8;
            4'h8: c = 8'h80;
            4'h9: c = 8'h90;
            4'hA: c = 8'h88;
            4'hB: c = 8'h83;
            4'hC: c = 8'hC6;
            4'hD: c = 8'hA1;
            4'hE: c = 8'h86;
            4'hF: c = 8'h8E;
            default: c = BLANK_CODE;
        endcase
        return c;
    endfunction

    // anode codes are active low; cathode mode drives the complement
    function automatic logic [7:0] for_mode(input logic cathode, input logic [7:0] code);
        return cathode ? ~code : code;
    endfunction

endpackage

[hdl/ssd_bcd_cell.sv]
// One BCD digit of the binary-to-decimal shift chain (shift and add-3).
// Depends on ssd_pkg.
module ssd_bcd_cell
    import ssd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_clear,
    input  logic       i_shift,
    input  logic       i_bit,
    output logic [3:0] o_digit,
    output logic       o_carry
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_clear) begin
            n_digit = 4'd0;
        end else if (i_shift) begin
            n_digit = {w_adj[2:0], i_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

[hdl/ssd_bcd_chain.sv]
// Row of BCD cells; each shift cycle a magnitude bit enters cell 0, carries go left.
// Depends on ssd_pkg and ssd_bcd_cell.
module ssd_bcd_chain
    import ssd_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    output t_bcd       o_digits,
    output logic       o_overflow
);

    logic [BCD_DIGITS-1:0] w_carry;

    for (genvar k = 0; k < BCD_DIGITS; k++) begin : g_cell
        logic w_in;
        if (k == 0) begin : g_first
            assign w_in = i_ctl.bit_in;
        end else begin : g_next
            assign w_in = w_carry[k-1];
        end
        ssd_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_clear (i_ctl.clear),
            .i_shift (i_ctl.shift),
            .i_bit   (w_in),
            .o_digit (o_digits[k]),
            .o_carry (w_carry[k])
        );
    end

    // a carry out of the top digit would mean a lost decimal digit
    assign o_overflow = w_carry[BCD_DIGITS-1];

endmodule

[hdl/ssd_scan.sv]
// Scan timer: lit and blank phases per digit, advancing the scanned digit index.
// Depends on ssd_pkg.
module ssd_scan
    import ssd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick,
    input  logic [15:0] i_on_ticks,
    input  logic [15:0] i_off_ticks,
    input  logic [3:0]  i_used,
    output t_scan       o_scan
);

    logic [2:0]  r_index;
    logic [15:0] r_phase;
    logic        r_blank;
    logic [2:0]  n_index;
    logic [15:0] n_phase;
    logic        n_blank;
    logic [15:0] w_cnt;
    logic [15:0] w_on_len;
    logic [3:0]  w_next;
    logic [2:0]  w_adv;

    assign w_cnt    = r_phase + 16'd1;
    assign w_on_len = (i_on_ticks == 16'd0) ? 16'd1 : i_on_ticks;
    assign w_next   = {1'b0, r_index} + 4'd1;
    assign w_adv    = (w_next >= i_used) ? 3'd0 : w_next[2:0];

    always_comb begin
        n_index = r_index;
        n_phase = r_phase;
        n_blank = r_blank;
        if (i_tick) begin
            n_phase = w_cnt;
            if (!r_blank) begin
                if (w_cnt >= w_on_len) begin
                    n_phase = 16'd0;
                    if (i_off_ticks != 16'd0) begin
                        n_blank = 1'b1;
                    end else begin
                        n_index = w_adv;
                    end
                end
            end else if (w_cnt >= i_off_ticks) begin
                n_phase = 16'd0;
                n_blank = 1'b0;
                n_index = w_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= 3'd0;
            r_phase <= 16'd0;
            r_blank <= 1'b0;
        end else begin
            r_index <= n_index;
            r_phase <= n_phase;
            r_blank <= n_blank;
        end
    end

    assign o_scan.index = r_index;
    assign o_scan.blank = r_blank;

endmodule

[hdl/seven_segment_scan_driver_top.sv]
// Multiplexed seven-segment driver. Each request gives one result: the segment byte and
// digit enables driven after it. A number goes through the BCD shift chain, one magnitude
// bit per cycle, then the load state writes the digit codes and marks the result pending.
// Every other request marks its result pending when it is taken. A pending result is
// registered onto the outputs once the output is not stalled. The input stalls from a
// request until its result has been registered, so only one request is ever being processed.
// Configuration writes are always ready.
module seven_segment_scan_driver_top
    import ssd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_kind,
    input  logic signed [31:0] i_number,
    input  logic [2:0]  i_position,
    input  logic [3:0]  i_hex_value,
    input  logic        i_with_point,
    input  logic        i_symbol_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_segment_byte,
    output logic [7:0]  o_digit_select,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic        r_cathode;
    logic [3:0]  r_digit_count;
    logic [15:0] r_on_ticks;
    logic [15:0] r_off_ticks;
    logic [7:0]  r_codes [MAX_DIGITS];
    logic [7:0]  n_codes [MAX_DIGITS];
    logic [MAG_W-1:0] r_mag;
    logic        r_neg;
    logic [CNT_W-1:0] r_bit_cnt;
    logic        r_pend;
    logic        r_out_valid;
    logic [7:0]  r_seg;
    logic [7:0]  r_sel;

    logic        w_in_acc;
    logic        w_cfg_acc;
    logic [3:0]  w_used;
    logic [3:0]  w_len;
    logic [MAG_W-1:0] w_bits;
    logic [MAG_W-1:0] w_abs;
    t_chain_ctl  w_ctl;
    t_bcd        w_digits;
    logic        w_ovf;
    t_scan       w_scan;
    logic        w_take;
    logic [7:0]  w_seg;
    logic [7:0]  w_sel;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid;
    assign o_in_stall  = (r_state != S_IDLE) || r_pend;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    assign w_used = (r_digit_count == 4'd0) ? 4'd1 :
                    (r_digit_count > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : r_digit_count;

    assign w_bits = i_number;
    assign w_abs  = i_number[31] ? (32'd0 - w_bits) : w_bits;

    assign w_ctl.clear  = w_in_acc && (i_kind == K_NUMBER);
    assign w_ctl.shift  = (r_state == S_CONV);
    assign w_ctl.bit_in = r_mag[MAG_W-1];

    ssd_bcd_chain u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .o_digits   (w_digits),
        .o_overflow (w_ovf)
    );

    ssd_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_in_acc && (i_kind == K_TICK)),
        .i_on_ticks  (r_on_ticks),
        .i_off_ticks (r_off_ticks),
        .i_used      (w_used),
        .o_scan      (w_scan)
    );

    // number of significant decimal digits, at least one
    always_comb begin
        w_len = 4'd1;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (w_digits[k] != 4'd0) begin
                w_len = 4'(k + 1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_acc && i_kind == K_NUMBER) n_state = S_CONV;
            S_CONV: if (r_bit_cnt == CNT_W'(MAG_W - 1)) n_state = S_LOAD;
            S_LOAD: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            n_codes[i] = r_codes[i];
            if (r_state == S_LOAD && 4'(i) < w_used) begin
                if (4'(i) >= w_len) begin
                    n_codes[i] = for_mode(r_cathode, BLANK_CODE);
                end else begin
                    n_codes[i] = for_mode(r_cathode, hex_code(w_digits[i]));
                end
                if (r_neg && w_len < w_used && w_len == 4'(i)) begin
                    n_codes[i] = for_mode(r_cathode, MINUS_CODE);
                end
            end else if (w_in_acc && i_position == 3'(i)) begin
                case (i_kind)
                    K_HEX: begin
                        n_codes[i] = for_mode(r_cathode, i_with_point ?
                            (hex_code(i_hex_value) & POINT_MASK) : hex_code(i_hex_value));
                    end
                    K_SYMBOL: begin
                        if (!i_symbol_code) begin
                            n_codes[i] = for_mode(r_cathode, MINUS_CODE);
                        end else if (r_cathode) begin
                            n_codes[i] = r_codes[i] | POINT_BIT;
                        end else begin
                            n_codes[i] = r_codes[i] & POINT_MASK;
                        end
                    end
                    K_BLANK: n_codes[i] = for_mode(r_cathode, BLANK_CODE);
                    default: n_codes[i] = r_codes[i];
                endcase
            end
        end
    end

    assign w_seg  = r_codes[w_scan.index[IDX_W-1:0]];
    assign w_sel  = w_scan.blank ? (r_cathode ? SEL_OFF_CC : SEL_OFF_CA)
                                 : for_mode(r_cathode, 8'd1 << w_scan.index);
    assign w_take = r_pend && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cathode     <= 1'b0;
            r_digit_count <= 4'd8;
            r_on_ticks    <= 16'd1000;
            r_off_ticks   <= 16'd0;
            r_bit_cnt     <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_codes[i] <= BLANK_CODE;
            end
        end else begin
            r_state <= n_state;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_codes[i] <= n_codes[i];
            end
            if (w_cfg_acc) begin
                case (i_cfg_index)
                    CFG_CATHODE: r_cathode     <= i_cfg_data[0];
                    CFG_COUNT:   r_digit_count <= i_cfg_data[3:0];
                    CFG_ON:      r_on_ticks    <= i_cfg_data;
                    CFG_OFF:     r_off_ticks   <= i_cfg_data;
                    default:     r_cathode     <= r_cathode;
                endcase
            end
            if (r_state == S_CONV) begin
                r_bit_cnt <= r_bit_cnt + CNT_W'(1);
            end else begin
                r_bit_cnt <= '0;
            end
            if ((w_in_acc && i_kind != K_NUMBER) || r_state == S_LOAD) begin
                r_pend <= 1'b1;
            end else if (w_take) begin
                r_pend <= 1'b0;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_kind == K_NUMBER) begin
            r_mag <= w_abs;
            r_neg <= i_number[31];
        end else if (r_state == S_CONV) begin
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
        end
        if (w_take) begin
            r_seg <= w_seg;
            r_sel <= w_sel;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_segment_byte = r_seg;
    assign o_digit_select = r_sel;

    a_no_bcd_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.shift |-> !w_ovf)
        else $error("BCD chain lost a digit");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("request accepted during conversion");

    a_update_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_kind != K_NUMBER) |=> r_pend)
        else $error("update request gave no result");

    a_conv_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && r_bit_cnt == CNT_W'(MAG_W - 1)) |=> (r_state == S_LOAD))
        else $error("conversion did not end after the last bit");

    a_load_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_pend && r_state == S_IDLE))
        else $error("number load gave no result");

endmodule
